>>> rtl/core/rtphp_pkg.sv
// Package for the RTP header parser: widths, status codes and the
// structs passed between the capture stage and the result register.
// No dependencies.
package rtphp_pkg;

    localparam int COUNT_BITS     = 19;
    localparam int LEN_BITS       = COUNT_BITS + 1;
    localparam int OFF_BITS       = 19;
    localparam int EXT_BYTES_BITS = 18;
    localparam int HDR_BYTES      = 12;
    localparam int EXT_HDR_BYTES  = 4;

    localparam logic [1:0] RTP_VERSION = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BAD_VER  = 3'd2;
    localparam logic [2:0] ST_CSRC_OVR = 3'd3;
    localparam logic [2:0] ST_EXTH_OVR = 3'd4;
    localparam logic [2:0] ST_EXTD_OVR = 3'd5;

    // Header bytes as captured up to and including the final byte
    typedef struct packed {
        logic [7:0]          byte0;
        logic [7:0]          byte1;
        logic [15:0]         seq;
        logic [31:0]         ts;
        logic [31:0]         ssrc;
        logic [15:0]         ext_id;
        logic [15:0]         ext_words;
        logic [LEN_BITS-1:0] len;
    } hdr_snap_t;

    typedef struct packed {
        logic [2:0]                status;
        logic                      padding;
        logic                      extension;
        logic [3:0]                csrc_cnt;
        logic                      marker;
        logic [6:0]                pay_type;
        logic [15:0]               sequence_res;
        logic [31:0]               timestamp;
        logic [31:0]               ssrc;
        logic [15:0]               ext_profile;
        logic [EXT_BYTES_BITS-1:0] ext_len_bytes;
        logic [OFF_BITS-1:0]       pay_offset;
    } res_t;

endpackage

>>> rtl/core/rtphp_if.sv
// Valid/ready channel interfaces for the RTP header parser: the byte
// input channel and the parsed result channel. Depends on rtphp_pkg.
interface rtphp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtphp_out_if import rtphp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic                      padding;
    logic                      extension;
    logic [3:0]                csrc_cnt;
    logic                      marker;
    logic [6:0]                pay_type;
    logic [15:0]               sequence_res;
    logic [31:0]               timestamp;
    logic [31:0]               ssrc;
    logic [15:0]               ext_profile;
    logic [EXT_BYTES_BITS-1:0] ext_len_bytes;
    logic [OFF_BITS-1:0]       pay_offset;

    modport source (
        output valid, output status, output padding, output extension,
        output csrc_cnt, output marker, output pay_type,
        output sequence_res, output timestamp, output ssrc,
        output ext_profile, output ext_len_bytes, output pay_offset,
        input  ready
    );
    modport sink (
        input  valid, input status, input padding, input extension,
        input  csrc_cnt, input marker, input pay_type,
        input  sequence_res, input timestamp, input ssrc,
        input  ext_profile, input ext_len_bytes, input pay_offset,
        output ready
    );
endinterface

>>> rtl/core/rtp_header_parser_unit.sv
// RTP header parser top level: byte capture, snapshot stage and result
// register. Depends on rtphp_pkg and the channel interfaces in rtphp_if.
//
// Takes one packet byte per transfer and accepts a byte every cycle while
// the input is not stalled. The fixed header and the extension header are
// captured as bytes go by; on the final byte the captured header and
// length move to a snapshot register and the capture state clears, so the
// next packet may start in the following cycle. The status checks and
// offset adds run between the snapshot and the result register, which
// offers the result. Back-pressure on the result channel stalls the input
// only when both the snapshot and the result register hold a packet. The
// byte counter saturates at 2^19-1.
module rtp_header_parser_unit
    import rtphp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rtphp_in_if.sink     pkt,
    rtphp_out_if.source  res
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] count_reg;
    logic [7:0]            byte0_reg;
    logic [7:0]            byte1_reg;
    logic [15:0]           seq_reg;
    logic [31:0]           ts_reg;
    logic [31:0]           ssrc_reg;
    logic [15:0]           ext_id_reg;
    logic [15:0]           ext_words_reg;

    hdr_snap_t             cap_next;
    hdr_snap_t             snap_reg;
    logic                  snap_valid_reg;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  res_valid_reg;

    logic                  accept;
    logic                  out_free;
    logic [COUNT_BITS-1:0] ext_base;
    logic [COUNT_BITS-1:0] ext_rel;
    logic                  in_ext_hdr;

    logic [LEN_BITS-1:0]   off_csrc;
    logic [LEN_BITS-1:0]   off_ext_hdr;
    logic [LEN_BITS-1:0]   off_ext_data;
    logic [EXT_BYTES_BITS-1:0] ext_bytes;

    assign out_free  = !res_valid_reg || res.ready;
    assign pkt.ready = !snap_valid_reg || out_free;
    assign accept    = pkt.valid && pkt.ready;

    // Extension header sits right after the CSRC list
    assign ext_base   = COUNT_BITS'(HDR_BYTES) + COUNT_BITS'({byte0_reg[3:0], 2'b00});
    assign ext_rel    = count_reg - ext_base;
    assign in_ext_hdr = (count_reg >= COUNT_BITS'(HDR_BYTES)) && byte0_reg[4]
                        && (count_reg >= ext_base)
                        && (ext_rel < COUNT_BITS'(EXT_HDR_BYTES));

    always_comb
    begin
        cap_next.byte0     = byte0_reg;
        cap_next.byte1     = byte1_reg;
        cap_next.seq       = seq_reg;
        cap_next.ts        = ts_reg;
        cap_next.ssrc      = ssrc_reg;
        cap_next.ext_id    = ext_id_reg;
        cap_next.ext_words = ext_words_reg;
        cap_next.len       = LEN_BITS'(count_reg) + LEN_BITS'(1);
        if (count_reg == COUNT_BITS'(0))
        begin
            cap_next.byte0 = pkt.data_byte;
        end
        else if (count_reg == COUNT_BITS'(1))
        begin
            cap_next.byte1 = pkt.data_byte;
        end
        else if (count_reg < COUNT_BITS'(4))
        begin
            cap_next.seq = {seq_reg[7:0], pkt.data_byte};
        end
        else if (count_reg < COUNT_BITS'(8))
        begin
            cap_next.ts = {ts_reg[23:0], pkt.data_byte};
        end
        else if (count_reg < COUNT_BITS'(HDR_BYTES))
        begin
            cap_next.ssrc = {ssrc_reg[23:0], pkt.data_byte};
        end
        else if (in_ext_hdr)
        begin
            if (!ext_rel[1])
                cap_next.ext_id = {ext_id_reg[7:0], pkt.data_byte};
            else
                cap_next.ext_words = {ext_words_reg[7:0], pkt.data_byte};
        end
    end

    // Capture state: clear on the final byte of a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            byte0_reg     <= '0;
            byte1_reg     <= '0;
            seq_reg       <= '0;
            ts_reg        <= '0;
            ssrc_reg      <= '0;
            ext_id_reg    <= '0;
            ext_words_reg <= '0;
        end
        else if (accept)
        begin
            if (pkt.last_byte)
            begin
                count_reg     <= '0;
                byte0_reg     <= '0;
                byte1_reg     <= '0;
                seq_reg       <= '0;
                ts_reg        <= '0;
                ssrc_reg      <= '0;
                ext_id_reg    <= '0;
                ext_words_reg <= '0;
            end
            else
            begin
                if (count_reg != COUNT_MAX)
                    count_reg <= count_reg + COUNT_BITS'(1);
                byte0_reg     <= cap_next.byte0;
                byte1_reg     <= cap_next.byte1;
                seq_reg       <= cap_next.seq;
                ts_reg        <= cap_next.ts;
                ssrc_reg      <= cap_next.ssrc;
                ext_id_reg    <= cap_next.ext_id;
                ext_words_reg <= cap_next.ext_words;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (accept && pkt.last_byte)
            snap_valid_reg <= 1'b1;
        else if (out_free)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && pkt.last_byte)
            snap_reg <= cap_next;
    end

    // Status checks and payload offset from the snapshot
    assign off_csrc     = LEN_BITS'(HDR_BYTES) + LEN_BITS'({snap_reg.byte0[3:0], 2'b00});
    assign off_ext_hdr  = off_csrc + LEN_BITS'(EXT_HDR_BYTES);
    assign ext_bytes    = {snap_reg.ext_words, 2'b00};
    assign off_ext_data = off_ext_hdr + LEN_BITS'(ext_bytes);

    always_comb
    begin
        res_next = '0;
        if (snap_reg.len < LEN_BITS'(HDR_BYTES))
        begin
            res_next.status = ST_SHORT;
        end
        else
        begin
            res_next.padding      = snap_reg.byte0[5];
            res_next.extension    = snap_reg.byte0[4];
            res_next.csrc_cnt     = snap_reg.byte0[3:0];
            res_next.marker       = snap_reg.byte1[7];
            res_next.pay_type     = snap_reg.byte1[6:0];
            res_next.sequence_res = snap_reg.seq;
            res_next.timestamp    = snap_reg.ts;
            res_next.ssrc         = snap_reg.ssrc;
            if (snap_reg.byte0[7:6] != RTP_VERSION)
            begin
                res_next.status = ST_BAD_VER;
            end
            else if (off_csrc > snap_reg.len)
            begin
                res_next.status = ST_CSRC_OVR;
            end
            else if (!snap_reg.byte0[4])
            begin
                res_next.status     = ST_OK;
                res_next.pay_offset = off_csrc[OFF_BITS-1:0];
            end
            else if (off_ext_hdr > snap_reg.len)
            begin
                res_next.status = ST_EXTH_OVR;
            end
            else
            begin
                res_next.ext_profile   = snap_reg.ext_id;
                res_next.ext_len_bytes = ext_bytes;
                if (off_ext_data > snap_reg.len)
                begin
                    res_next.status = ST_EXTD_OVR;
                end
                else
                begin
                    res_next.status     = ST_OK;
                    res_next.pay_offset = off_ext_data[OFF_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_free)
            res_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && snap_valid_reg)
            res_reg <= res_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_reg.status;
    assign res.padding       = res_reg.padding;
    assign res.extension     = res_reg.extension;
    assign res.csrc_cnt      = res_reg.csrc_cnt;
    assign res.marker        = res_reg.marker;
    assign res.pay_type      = res_reg.pay_type;
    assign res.sequence_res  = res_reg.sequence_res;
    assign res.timestamp     = res_reg.timestamp;
    assign res.ssrc          = res_reg.ssrc;
    assign res.ext_profile   = res_reg.ext_profile;
    assign res.ext_len_bytes = res_reg.ext_len_bytes;
    assign res.pay_offset    = res_reg.pay_offset;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pkt.last_byte |=> count_reg == '0 && byte0_reg == '0)
        else $error("capture state not cleared after final byte");

    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_OK
            |-> res.pay_offset >= OFF_BITS'(HDR_BYTES))
        else $error("payload offset inside fixed header on good packet");

    a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_SHORT
            |-> res.timestamp == '0 && res.ssrc == '0 && res.csrc_cnt == '0)
        else $error("short packet carries header fields");

    a_no_ext_id: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.extension |-> res.ext_profile == '0
            && res.ext_len_bytes == '0)
        else $error("extension fields set with extension bit clear");

endmodule
